/* hw/rtl/swtf_pkg.sv */
// Shared constants and types for the sliding-window tag frequency block.
package swtf_pkg;

	localparam int WINDOW_DEPTH = 256;
	localparam int TAG_SPACE    = 256;

	localparam int TAG_W  = 8;
	localparam int CNT_W  = 9;
	localparam int FRAC_W = 17;
	localparam int SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int CTAG_W = $clog2(TAG_SPACE);
	localparam int STEP_W = $clog2(FRAC_W);

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_OLDRD = 7'b0000010,
		S_DEC   = 7'b0000100,
		S_TAGRD = 7'b0001000,
		S_TAG   = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_DONE  = 7'b1000000
	} seq_state_t;

	typedef struct packed {
		logic go;
		logic done;
	} div_ctl_t;

endpackage

/* hw/rtl/swtf_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module swtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/swtf_div.sv */
// Radix-2 restoring divider: floor(num * 2^16 / den), one quotient bit per cycle.
module swtf_div import swtf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [CNT_W-1:0]  num,
	input  logic [CNT_W-1:0]  den,
	output logic              done,
	output logic [FRAC_W-1:0] quot
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]    rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [FRAC_W-1:0] quot_q;
	logic              ge;
	logic [CNT_W:0]    diff;
	logic [CNT_W:0]    rem_next;

	// num <= den, so the partial remainder stays below 2*den.
	assign ge       = rem_q >= {1'b0, den_q};
	assign diff     = rem_q - {1'b0, den_q};
	assign rem_next = ge ? diff : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(FRAC_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= {rem_next[CNT_W-1:0], 1'b0};
			quot_q <= {quot_q[FRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* hw/rtl/sliding_window_tag_frequency_top.sv */
// Top level of the sliding-window tag frequency block: sequencer, ring and count stores.
//
// Usage:
//   Command channel: an item (op, tag) is taken at a clock edge with start high
//   and busy low. op = record appends a nonzero tag to the window (evicting the
//   oldest event once the window is at capacity); op = query only looks up.
//   Every transaction returns tag_count, fill_level and fraction =
//   floor(tag_count * 2^16 / fill_level) in Q1.16, or 0 for an empty window.
//   Result channel: result_valid is high for exactly one cycle with the result
//   fields; the receiver cannot stall, so the result must be taken then.
//   Sequence: S_OLDRD after the accept edge, then S_DEC for a record into a full
//   window (an extra state to fetch and decrement the evicted tag's count),
//   S_TAGRD, S_TAG, S_DIV and S_DONE, the result strobe. In S_DIV the radix-2
//   divider produces one quotient bit per cycle; no new item is taken until
//   busy falls. busy stays high until the strobe cycle has passed.
//   Configuration: cfg_data carries window_capacity, written on cfg_valid and
//   cfg_ready (ready only while idle with start low). A write clamps 0 to 1 and
//   anything above the ring depth to the ring depth, and empties the window.
//   Reset: capacity returns to 256, the window is empty; per-tag valid bits
//   make all counts read as zero at once, so no clearing pass is needed.
module sliding_window_tag_frequency_top import swtf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              op,
	input  logic [TAG_W-1:0]  tag,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data,
	output logic              result_valid,
	output logic [CNT_W-1:0]  tag_count,
	output logic [CNT_W-1:0]  fill_level,
	output logic [FRAC_W-1:0] fraction
);

	seq_state_t state_q;

	logic              op_q;
	logic [TAG_W-1:0]  tag_q;
	logic [CTAG_W-1:0] old_q;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  held_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [TAG_SPACE-1:0] cvalid_q;

	logic              accept;
	logic              cfg_wr;
	logic              tag_ok;
	logic              evict;
	logic [CNT_W-1:0]  cap_clamped;

	// Ring store
	logic              ring_we;
	logic [TAG_W-1:0]  ring_rdata;

	// Count store
	logic              cnt_we;
	logic [CTAG_W-1:0] cnt_waddr;
	logic [CNT_W-1:0]  cnt_wdata;
	logic [CTAG_W-1:0] cnt_raddr;
	logic [CNT_W-1:0]  cnt_rdata;
	logic [CNT_W-1:0]  old_cnt;
	logic [CNT_W-1:0]  cur_cnt;
	logic [CNT_W-1:0]  new_cnt;
	logic              recording;

	logic [CNT_W-1:0]  slot_inc;
	logic [CNT_W-1:0]  held_inc;

	div_ctl_t          div_ctl;
	logic [FRAC_W-1:0] div_quot;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	// a command in the same cycle wins, so the write never drops a transaction
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign tag_ok = (tag_q != '0) && (32'(tag_q) < 32'(TAG_SPACE));
	assign evict  = (op_q == OP_RECORD) && tag_ok && (held_q == cap_q);

	always_comb begin
		if (cfg_data == '0) begin
			cap_clamped = CNT_W'(1);
		end else if (32'(cfg_data) > 32'(WINDOW_DEPTH)) begin
			cap_clamped = CNT_W'(WINDOW_DEPTH);
		end else begin
			cap_clamped = cfg_data;
		end
	end

	// Event ring: always read at the write slot, so the oldest tag is ready in
	// S_OLDRD, the cycle after accept.
	swtf_ram #(
		.WIDTH (TAG_W),
		.DEPTH (WINDOW_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (slot_q),
		.wdata (tag_q),
		.raddr (slot_q),
		.rdata (ring_rdata)
	);

	swtf_ram #(
		.WIDTH (CNT_W),
		.DEPTH (TAG_SPACE)
	) u_counts (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// Entries never written since the window was emptied read as zero.
	assign old_cnt   = cvalid_q[old_q] ? cnt_rdata : '0;
	assign cur_cnt   = cvalid_q[CTAG_W'(tag_q)] ? cnt_rdata : '0;
	assign recording = (op_q == OP_RECORD) && tag_ok;
	assign new_cnt   = cur_cnt + 1'b1;

	assign cnt_raddr = (state_q == S_OLDRD) ? CTAG_W'(ring_rdata) : CTAG_W'(tag_q);

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = CTAG_W'(tag_q);
		cnt_wdata = new_cnt;
		ring_we   = 1'b0;
		case (state_q)
			S_DEC: begin
				// saturating decrement of the evicted tag's count
				cnt_waddr = old_q;
				cnt_wdata = old_cnt - 1'b1;
				cnt_we    = (old_q != '0) && (old_cnt != '0);
			end
			S_TAG: begin
				cnt_we  = recording;
				ring_we = recording;
			end
			default: begin
				cnt_we = 1'b0;
			end
		endcase
	end

	assign slot_inc = CNT_W'(slot_q) + 1'b1;
	assign held_inc = held_q + 1'b1;

	assign div_ctl.go = (state_q == S_TAG);

	swtf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_ctl.go),
		.num    (recording ? new_cnt : (tag_ok ? cur_cnt : '0)),
		.den    (recording && !evict ? held_inc : held_q),
		.done   (div_ctl.done),
		.quot   (div_quot)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cap_q    <= CNT_W'(WINDOW_DEPTH);
			held_q   <= '0;
			slot_q   <= '0;
			cvalid_q <= '0;
		end else begin
			if (cnt_we) begin
				cvalid_q[cnt_waddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_wr) begin
						cap_q    <= cap_clamped;
						held_q   <= '0;
						slot_q   <= '0;
						cvalid_q <= '0;
					end else if (accept) begin
						state_q <= S_OLDRD;
					end
				end
				S_OLDRD: begin
					state_q <= evict ? S_DEC : S_TAGRD;
				end
				S_DEC: begin
					state_q <= S_TAGRD;
				end
				S_TAGRD: begin
					state_q <= S_TAG;
				end
				S_TAG: begin
					if (recording) begin
						if (held_q < cap_q) begin
							held_q <= held_inc;
							slot_q <= (held_inc == cap_q) ? '0 : SLOT_W'(held_inc);
						end else begin
							slot_q <= (slot_inc == cap_q) ? '0 : SLOT_W'(slot_inc);
						end
					end
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_ctl.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			tag_q <= tag;
		end
		if (state_q == S_OLDRD) begin
			old_q <= CTAG_W'(ring_rdata);
		end
		if (state_q == S_TAG) begin
			count_q <= recording ? new_cnt : (tag_ok ? cur_cnt : '0);
		end
	end

	assign result_valid = (state_q == S_DONE);
	assign tag_count    = count_q;
	assign fill_level   = held_q;
	assign fraction     = (held_q == '0) ? '0 : div_quot;

endmodule
